/* hdl/pps_pkg.sv */
`timescale 1ns / 1ps
// Package for the preemptive priority scheduler: sizes, command codes and
// the packed item and candidate types used by the cell row and the top level.
// Depends on nothing.
package pps_pkg;

    localparam int MAX_TASKS   = 16;
    localparam int SLOT_W      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W       = $clog2(MAX_TASKS + 1);
    localparam int TIME_W      = 16;
    localparam int PRIO_W      = 10;
    localparam int TASK_SLOT_W = 6;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic              command;
        logic [TIME_W-1:0] burst_length;
        logic [TIME_W-1:0] arrival_tick;
        logic [PRIO_W-1:0] task_priority;
    } t_in_item;

    typedef struct packed {
        logic                   ran_task;
        logic [TASK_SLOT_W-1:0] task_slot;
        logic [TIME_W-1:0]      run_length;
        logic [TIME_W-1:0]      tick_after;
        logic                   task_finished;
        logic [TIME_W-1:0]      turnaround;
        logic [TIME_W-1:0]      waiting;
        logic                   all_done;
    } t_out_item;

    // Best task seen so far as the selection passes along the cell row.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [SLOT_W-1:0] slot;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
    } t_cand;

endpackage

/* hdl/pps_cell.sv */
`timescale 1ns / 1ps
// One task slot of the scheduler row: holds the task and merges it into the
// running best candidate handed on from the previous cell. Uses pps_pkg.
module pps_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pps_pkg::SLOT_W-1:0]    i_slot,
    input  logic                          i_load,
    input  pps_pkg::t_in_item             i_load_data,
    input  logic [pps_pkg::TIME_W-1:0]    i_time,
    input  logic                          i_dec,
    input  pps_pkg::t_cand                i_cand,
    output pps_pkg::t_cand                o_cand
);
    import pps_pkg::*;

    logic              r_loaded;
    logic              r_done;
    logic [TIME_W-1:0] r_burst;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_arr;
    logic [PRIO_W-1:0] r_prio;
    t_cand             r_cand;
    t_cand             n_cand;
    logic              w_eligible;
    logic              w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
            r_done   <= 1'b0;
        end else if (i_load) begin
            r_loaded <= 1'b1;
            r_done   <= (i_load_data.burst_length == '0);
        end else if (i_dec && r_rem == TIME_W'(1)) begin
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_load_data.burst_length;
            r_rem   <= i_load_data.burst_length;
            r_arr   <= i_load_data.arrival_tick;
            r_prio  <= i_load_data.task_priority;
        end else if (i_dec) begin
            r_rem <= r_rem - TIME_W'(1);
        end
    end

    // The incoming candidate comes from lower slots, so it keeps full ties.
    always_comb begin
        w_eligible = r_loaded && !r_done && (r_arr <= i_time);
        w_take     = w_eligible && (!i_cand.valid || (r_prio < i_cand.prio) ||
                     ((r_prio == i_cand.prio) && (r_arr < i_cand.arrival)));
        if (w_take) begin
            n_cand.valid   = 1'b1;
            n_cand.last    = (r_rem == TIME_W'(1));
            n_cand.slot    = i_slot;
            n_cand.prio    = r_prio;
            n_cand.arrival = r_arr;
            n_cand.burst   = r_burst;
        end else begin
            n_cand = i_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= '0;
        end else begin
            r_cand <= n_cand;
        end
    end

    assign o_cand = r_cand;

endmodule

/* hdl/preemptive_priority_scheduler_top.sv */
`timescale 1ns / 1ps
// Top level of the preemptive priority scheduler: control sequencer, counters
// and output register around a row of pps_cell instances. Uses pps_pkg.
//
// Usage. Items arrive on the input channel (i_in_valid, o_in_stall,
// i_in_data). A load command stores a task descriptor in the next free slot
// and gives no result; loads beyond the table size are dropped.
// A tick command selects the task to run and gives exactly one result on the
// output channel (o_out_valid, i_out_stall, o_out_data).
// A load leaves the block idle and ready for the next item. A tick passes
// through the accept step, then the scan, while the best candidate travels
// one cell per cycle along the row of task cells, then the update step that
// writes the result register. The next item can be taken once that write is
// done. Items are taken one at a time.
// The result register parts the two channels: a new item is accepted while
// an earlier result still waits. When the receiver stalls, the result holds
// steady and a following tick waits in its update step until the pending
// transfer completes.
// Reset (synchronous, active low) empties the task table, clears the time,
// completion and run counters and forgets the previously running task.
module preemptive_priority_scheduler_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pps_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pps_pkg::t_out_item o_out_data
);
    import pps_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]        r_state,     n_state;
    logic [SLOT_W-1:0] r_scan_cnt,  n_scan_cnt;
    logic [CNT_W-1:0]  r_loaded,    n_loaded;
    logic [CNT_W-1:0]  r_completed, n_completed;
    logic [TIME_W-1:0] r_time,      n_time;
    logic              r_prev_valid, n_prev_valid;
    logic [SLOT_W-1:0] r_prev_slot,  n_prev_slot;
    logic [TIME_W-1:0] r_run,       n_run;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out,       n_out;

    logic              w_in_xfer;
    logic              w_out_xfer;
    logic              w_load;
    logic              w_update;
    logic [TIME_W-1:0] w_tat;
    t_cand             w_win;
    t_cand             w_chain [0:MAX_TASKS];
    logic [MAX_TASKS-1:0] w_load_sel;
    logic [MAX_TASKS-1:0] w_dec_sel;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_out_xfer  = r_out_valid && !i_out_stall;
    assign w_load      = w_in_xfer && (i_in_data.command == CMD_LOAD) &&
                         (r_loaded < CNT_W'(MAX_TASKS));
    // The update may write the result register once it is free or draining.
    assign w_update    = (r_state == ST_UPD) && (!r_out_valid || !i_out_stall);
    assign w_win       = w_chain[MAX_TASKS];

    // Row of task cells; the selection enters at slot zero with no candidate.
    assign w_chain[0] = '0;

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        assign w_load_sel[g] = w_load && (r_loaded == CNT_W'(g));
        assign w_dec_sel[g]  = w_update && w_win.valid && (w_win.slot == SLOT_W'(g));

        pps_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_slot      (SLOT_W'(g)),
            .i_load      (w_load_sel[g]),
            .i_load_data (i_in_data),
            .i_time      (r_time),
            .i_dec       (w_dec_sel[g]),
            .i_cand      (w_chain[g]),
            .o_cand      (w_chain[g+1])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_scan_cnt   = r_scan_cnt;
        n_loaded     = r_loaded;
        n_completed  = r_completed;
        n_time       = r_time;
        n_prev_valid = r_prev_valid;
        n_prev_slot  = r_prev_slot;
        n_run        = r_run;
        n_out_valid  = r_out_valid && !w_out_xfer;
        n_out        = r_out;
        w_tat        = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_load) begin
                    n_loaded = r_loaded + CNT_W'(1);
                    if (i_in_data.burst_length == '0) begin
                        n_completed = r_completed + CNT_W'(1);
                    end
                end
                if (w_in_xfer && (i_in_data.command == CMD_TICK)) begin
                    n_state    = ST_SCAN;
                    n_scan_cnt = '0;
                end
            end
            ST_SCAN: begin
                // Wait until the candidate has passed every cell.
                if (r_scan_cnt == SLOT_W'(MAX_TASKS - 1)) begin
                    n_state = ST_UPD;
                end else begin
                    n_scan_cnt = r_scan_cnt + SLOT_W'(1);
                end
            end
            ST_UPD: begin
                if (w_update) begin
                    n_time = (r_time == TIME_MAX) ? r_time : r_time + TIME_W'(1);
                    n_out  = '0;
                    if (w_win.valid) begin
                        if (r_prev_valid && (r_prev_slot == w_win.slot)) begin
                            n_run = (r_run == TIME_MAX) ? r_run : r_run + TIME_W'(1);
                        end else begin
                            n_run        = TIME_W'(1);
                            n_prev_slot  = w_win.slot;
                            n_prev_valid = 1'b1;
                        end
                        n_out.ran_task   = 1'b1;
                        n_out.task_slot  = TASK_SLOT_W'(w_win.slot);
                        n_out.run_length = n_run;
                        if (w_win.last) begin
                            w_tat               = n_time - w_win.arrival;
                            n_completed         = r_completed + CNT_W'(1);
                            n_out.task_finished = 1'b1;
                            n_out.turnaround    = w_tat;
                            n_out.waiting       = (w_tat >= w_win.burst) ?
                                                  w_tat - w_win.burst : '0;
                        end
                    end
                    n_out.tick_after = n_time;
                    n_out.all_done   = (n_completed == r_loaded);
                    n_out_valid      = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_scan_cnt   <= '0;
            r_loaded     <= '0;
            r_completed  <= '0;
            r_time       <= '0;
            r_prev_valid <= 1'b0;
            r_prev_slot  <= '0;
            r_run        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_scan_cnt   <= n_scan_cnt;
            r_loaded     <= n_loaded;
            r_completed  <= n_completed;
            r_time       <= n_time;
            r_prev_valid <= n_prev_valid;
            r_prev_slot  <= n_prev_slot;
            r_run        <= n_run;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the preemptive priority scheduler: predicts every
// tick result from its own copy of the task table and compares each transfer.
// Depends on pps_pkg and preemptive_priority_scheduler_top.
module testbench;
    import pps_pkg::*;

    // Generous bound, many times the length of a full run.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int SETTLE_CYCLES = 2 * (MAX_TASKS + 2) + 4;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int MAX_REPORTS   = 100;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;

    preemptive_priority_scheduler_top u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Scheduler state as the testbench believes it to be. It is updated at the
    // moment each item is accepted, so it always runs ahead of the block.
    logic [TIME_W-1:0] task_burst   [MAX_TASKS];
    logic [TIME_W-1:0] task_left    [MAX_TASKS];
    logic [TIME_W-1:0] task_arrival [MAX_TASKS];
    logic [PRIO_W-1:0] task_prio    [MAX_TASKS];
    bit                task_done    [MAX_TASKS];
    int                tasks_loaded    = 0;
    int                tasks_completed = 0;
    logic [TIME_W-1:0] sched_now       = '0;
    bit                last_valid      = 1'b0;
    int                last_slot       = 0;
    logic [TIME_W-1:0] run_count       = '0;

    // Tick results that have been predicted but not yet seen on the output.
    t_out_item expected_results [$];

    int mismatches      = 0;
    int results_checked = 0;
    int ticks_sent      = 0;
    int loads_stored    = 0;
    int loads_dropped   = 0;
    int completions     = 0;
    int preemptions     = 0;
    int cycle_count     = 0;

    // Idling controls, changed by the test tasks.
    bit sender_gaps     = 1'b1;
    bit receiver_gaps   = 1'b1;
    int hold_off_cycles = 0;

    // Append a task to the table, or drop it when every slot is taken.
    function automatic void store_task(input t_in_item item);
        if (tasks_loaded >= MAX_TASKS) begin
            loads_dropped++;
            return;
        end
        task_burst[tasks_loaded]   = item.burst_length;
        task_left[tasks_loaded]    = item.burst_length;
        task_arrival[tasks_loaded] = item.arrival_tick;
        task_prio[tasks_loaded]    = item.task_priority;
        task_done[tasks_loaded]    = (item.burst_length == '0);
        if (task_done[tasks_loaded])
            tasks_completed++;
        tasks_loaded++;
        loads_stored++;
    endfunction

    // Run one time unit: pick the most urgent ready task, charge it one tick,
    // advance the clock and work out completion figures.
    function automatic t_out_item schedule_tick();
        t_out_item res;
        int        winner;
        res    = '0;
        winner = -1;
        for (int s = 0; s < tasks_loaded; s++) begin
            if (task_done[s] || task_arrival[s] > sched_now)
                continue;
            if (winner < 0 || task_prio[s] < task_prio[winner] ||
                (task_prio[s] == task_prio[winner] &&
                 task_arrival[s] < task_arrival[winner]))
                winner = s;
        end
        if (winner >= 0) begin
            if (last_valid && last_slot == winner) begin
                if (run_count != TIME_MAX)
                    run_count++;
            end else begin
                if (last_valid && !task_done[last_slot])
                    preemptions++;
                run_count  = 1;
                last_slot  = winner;
                last_valid = 1'b1;
            end
            task_left[winner]--;
            res.ran_task   = 1'b1;
            res.task_slot  = TASK_SLOT_W'(winner);
            res.run_length = run_count;
        end
        if (sched_now != TIME_MAX)
            sched_now++;
        if (winner >= 0 && task_left[winner] == '0) begin
            task_done[winner] = 1'b1;
            tasks_completed++;
            completions++;
            res.task_finished = 1'b1;
            res.turnaround    = sched_now - task_arrival[winner];
            res.waiting       = (res.turnaround >= task_burst[winner]) ?
                                res.turnaround - task_burst[winner] : '0;
        end
        res.tick_after = sched_now;
        res.all_done   = (tasks_completed == tasks_loaded);
        return res;
    endfunction

    function automatic t_in_item make_load(input logic [TIME_W-1:0] burst,
                                           input logic [TIME_W-1:0] arrival,
                                           input logic [PRIO_W-1:0] prio);
        t_in_item item;
        item.command       = CMD_LOAD;
        item.burst_length  = burst;
        item.arrival_tick  = arrival;
        item.task_priority = prio;
        return item;
    endfunction

    // The descriptor fields of a tick are don't-care, so they carry noise.
    function automatic t_in_item make_tick();
        t_in_item item;
        item = make_load(TIME_W'($urandom), TIME_W'($urandom), PRIO_W'($urandom));
        item.command = CMD_TICK;
        return item;
    endfunction

    // Mostly short bursts arriving soon, with a bias towards a few priority
    // values so that ties on priority and on arrival turn up often.
    function automatic t_in_item random_task();
        int unsigned       pick;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] arrival;
        logic [PRIO_W-1:0] prio;
        pick  = $urandom_range(0, 9);
        burst = (pick == 0) ? TIME_W'($urandom_range(1, 600)) :
                              TIME_W'($urandom_range(1, 24));
        pick = $urandom_range(0, 9);
        if (pick < 7)
            arrival = sched_now + TIME_W'($urandom_range(0, 40));
        else if (pick < 9)
            arrival = TIME_W'($urandom_range(0, sched_now));
        else
            arrival = TIME_W'($urandom);
        prio = ($urandom_range(0, 1) == 0) ? PRIO_W'($urandom_range(0, 3)) :
                                             PRIO_W'($urandom_range(0, 1023));
        return make_load(burst, arrival, prio);
    endfunction

    // Offer one item and hold it until the block takes it. Valid is only
    // lowered for a gap, so it is never dropped and raised in the same step.
    task automatic send_item(input t_in_item item);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        if (item.command == CMD_LOAD) begin
            store_task(item);
        end else begin
            expected_results.push_back(schedule_tick());
            ticks_sent++;
        end
    endtask

    // Stop offering and wait until every predicted result has been seen.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] result %0d: %s is 0x%0h, predicted 0x%0h",
                     $time, results_checked, what, got, want);
        mismatches++;
    endtask

    // An empty table, then a task with no work that is complete on arrival.
    task automatic test_empty_table();
        send_item(make_tick());
        send_item(make_load('0, '0, '0));
        send_item(make_tick());
        wait_for_results();
    endtask

    // Preemption by a more urgent arrival, ties broken by arrival time and
    // then by slot, a priority beyond the usual range, idle ticks while a task
    // is still to arrive, and ticks once everything has finished.
    task automatic test_priority_order();
        logic [TIME_W-1:0] base;
        base = sched_now;
        send_item(make_load(16'd3, base, 10'd500));
        send_item(make_load(16'd2, base + 16'd2, 10'd100));
        send_item(make_load(16'd2, base + 16'd1, 10'd100));
        send_item(make_load(16'd1, base + 16'd1, 10'd100));
        send_item(make_load(16'd1, base, 10'd1000));
        send_item(make_load(16'd2, base + 16'd12, 10'd7));
        repeat (15) send_item(make_tick());
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while ticks keep coming, so
    // the result register fills and the input side has to stall. Afterwards
    // the sender waits for every outstanding result before going on.
    task automatic test_receiver_hold_off();
        sender_gaps     = 1'b0;
        receiver_gaps   = 1'b0;
        send_item(make_load(16'd6, sched_now, 10'd2));
        hold_off_cycles = HOLD_OFF_LEN;
        repeat (8) send_item(make_tick());
        wait_for_results();
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    // Rounds of ticks with the odd task load between them. Two slots are kept
    // back for the table-full test.
    task automatic test_random_schedule();
        int sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            sender_gaps   = ($urandom_range(0, 3) != 0);
            receiver_gaps = ($urandom_range(0, 3) != 0);
            if (tasks_loaded < MAX_TASKS - 2 && $urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 2)) begin
                    if (tasks_loaded < MAX_TASKS - 2) begin
                        send_item(random_task());
                        sent++;
                    end
                end
            end
            repeat ($urandom_range(10, 70)) begin
                send_item(make_tick());
                sent++;
            end
        end
        wait_for_results();
    endtask

    // Fill the table, with two tasks that only arrive at the top of the clock
    // range, offer one load too many, then keep ticking. No idling here.
    task automatic test_table_full();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        while (tasks_loaded < MAX_TASKS - 2)
            send_item(random_task());
        send_item(make_load(16'd5, TIME_MAX, '0));
        send_item(make_load(TIME_MAX, TIME_MAX, '1));
        send_item(make_load(TIME_W'($urandom_range(1, 65535)), TIME_W'($urandom),
                            PRIO_W'($urandom)));
        repeat (60) send_item(make_tick());
        wait_for_results();
    endtask

    // Each result transfer is checked against the oldest prediction.
    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                report_mismatch("unpredicted result, tick_after", out_data.tick_after, 0);
            end else begin
                want = expected_results.pop_front();
                if (out_data.ran_task !== want.ran_task)
                    report_mismatch("ran_task", out_data.ran_task, want.ran_task);
                if (out_data.task_slot !== want.task_slot)
                    report_mismatch("task_slot", out_data.task_slot, want.task_slot);
                if (out_data.run_length !== want.run_length)
                    report_mismatch("run_length", out_data.run_length, want.run_length);
                if (out_data.tick_after !== want.tick_after)
                    report_mismatch("tick_after", out_data.tick_after, want.tick_after);
                if (out_data.task_finished !== want.task_finished)
                    report_mismatch("task_finished", out_data.task_finished,
                                    want.task_finished);
                if (out_data.turnaround !== want.turnaround)
                    report_mismatch("turnaround", out_data.turnaround, want.turnaround);
                if (out_data.waiting !== want.waiting)
                    report_mismatch("waiting", out_data.waiting, want.waiting);
                if (out_data.all_done !== want.all_done)
                    report_mismatch("all_done", out_data.all_done, want.all_done);
            end
        end
    end

    // Output side: random stall bursts, or one long hold-off when asked for.
    initial begin : result_receiver
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_cycles > 0) begin
                out_stall <= 1'b1;
                for (int n = 0; n < hold_off_cycles; n++)
                    @(posedge clk);
                hold_off_cycles = 0;
                out_stall <= 1'b0;
            end else if (receiver_gaps && $urandom_range(0, 6) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : test_sequence
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_priority_order();
        test_receiver_hold_off();
        test_random_schedule();
        test_table_full();

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d stored loads, %0d loads dropped on a full table, %0d ticks",
                 loads_stored, loads_dropped, ticks_sent);
        $display("with %0d results checked, %0d completions, %0d preemptions, final clock %0d.",
                 results_checked, completions, preemptions, sched_now);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/pps_pkg.sv
hdl/pps_cell.sv
hdl/preemptive_priority_scheduler_top.sv
dv/testbench.sv
